// File: rtl/slbc_pkg.sv
package slbc_pkg;

    localparam int CNT_W   = 16;
    localparam int LAYER_W = 8;

    localparam logic [1:0] ITEM_TICK  = 2'd0;
    localparam logic [1:0] ITEM_LINK  = 2'd1;
    localparam logic [1:0] ITEM_LAYER = 2'd2;

    localparam logic [1:0] LINK_OFF  = 2'd0;
    localparam logic [1:0] LINK_ADV  = 2'd1;
    localparam logic [1:0] LINK_CONN = 2'd2;

    localparam logic CFG_ADV_TICKS  = 1'b0;
    localparam logic CFG_STEP_TICKS = 1'b1;

    localparam logic [CNT_W-1:0] ADV_TICKS_RST  = 16'd100;
    localparam logic [CNT_W-1:0] STEP_TICKS_RST = 16'd400;

    typedef struct packed {
        logic [1:0]         mode;
        logic               link_connected;
        logic               link_open;
        logic               layer_activated;
        logic [LAYER_W-1:0] highest_layer;
    } t_in_item;

    typedef struct packed {
        logic led_on;
        logic blink_busy;
    } t_out_item;

endpackage

// File: rtl/slbc_in_if.sv
interface slbc_in_if;
    logic              valid;
    logic              ready;
    slbc_pkg::t_in_item data;

    modport source  (output valid, output data, input ready);
    modport sink    (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

// File: rtl/slbc_out_if.sv
interface slbc_out_if;
    logic               valid;
    logic               ready;
    slbc_pkg::t_out_item data;

    modport source  (output valid, output data, input ready);
    modport sink    (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

// File: rtl/status_led_blink_controller.sv
// An input beat passes through two registers, the input register and then the result register.
// Throughput: one beat per cycle; both stages advance together unless the result
// register is held by a stalled sink.
// Reset: synchronous, active low; clears the LED state, blink run, timers and
// restores both tick registers to their defaults.
module status_led_blink_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [slbc_pkg::CNT_W-1:0]    i_cfg_data,
    slbc_in_if.sink                       i_in,
    slbc_out_if.source                    o_out
);

    localparam int CW = slbc_pkg::CNT_W;
    localparam int LW = slbc_pkg::LAYER_W;

    logic [CW-1:0]       r_adv_ticks;
    logic [CW-1:0]       r_step_ticks;

    logic                r_in_valid;
    slbc_pkg::t_in_item  r_in;
    logic                r_out_valid;
    slbc_pkg::t_out_item r_out;

    logic [1:0]          r_link, n_link;
    logic                r_led, n_led;
    logic                r_adv_run, n_adv_run;
    logic                r_active, n_active;
    logic                r_phase_on, n_phase_on;
    logic [LW-1:0]       r_left, n_left;
    logic [LW-1:0]       r_req, n_req;
    logic                r_pending, n_pending;
    logic [CW-1:0]       r_tick, n_tick;

    logic                fire;
    logic [CW:0]         tick_nxt;
    logic                step_done;
    logic                adv_done;
    logic [LW-1:0]       left_dec;
    logic [1:0]          link_new;
    logic [1:0]          ra_link;
    logic                ra_adv_run;
    logic                ra_led;

    assign fire        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || fire;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign tick_nxt  = {1'b0, r_tick} + {{CW{1'b0}}, 1'b1};
    assign step_done = tick_nxt >= {1'b0, r_step_ticks};
    assign adv_done  = tick_nxt >= {1'b0, r_adv_ticks};
    assign left_dec  = (r_left != '0) ? r_left - {{(LW-1){1'b0}}, 1'b1} : '0;

    always_comb begin
        if (r_in.link_connected) begin
            link_new = slbc_pkg::LINK_CONN;
        end else if (r_in.link_open) begin
            link_new = slbc_pkg::LINK_ADV;
        end else begin
            link_new = slbc_pkg::LINK_OFF;
        end
    end

    // mode reapply, on the link in force after this beat
    assign ra_link    = (r_in.mode == slbc_pkg::ITEM_LINK) ? link_new : r_link;
    assign ra_adv_run = (ra_link == slbc_pkg::LINK_ADV);
    assign ra_led     = (ra_link == slbc_pkg::LINK_ADV)  ? !r_led :
                        (ra_link == slbc_pkg::LINK_CONN);

    always_comb begin
        n_link     = r_link;
        n_led      = r_led;
        n_adv_run  = r_adv_run;
        n_active   = r_active;
        n_phase_on = r_phase_on;
        n_left     = r_left;
        n_req      = r_req;
        n_pending  = r_pending;
        n_tick     = r_tick;
        unique case (r_in.mode)
            slbc_pkg::ITEM_TICK: begin
                if (r_active) begin
                    if (!step_done) begin
                        n_tick = tick_nxt[CW-1:0];
                    end else begin
                        n_tick = '0;
                        if (!r_phase_on) begin
                            n_phase_on = 1'b1;
                            n_led      = 1'b1;
                        end else if (left_dec != '0) begin
                            n_left     = left_dec;
                            n_phase_on = 1'b0;
                            n_led      = 1'b0;
                        end else begin
                            n_phase_on = 1'b0;
                            n_pending  = 1'b0;
                            if (r_pending && r_req != '0) begin
                                n_left    = r_req;
                                n_adv_run = 1'b0;
                                n_led     = 1'b0;
                            end else begin
                                n_left    = left_dec;
                                n_active  = 1'b0;
                                n_adv_run = ra_adv_run;
                                n_led     = ra_led;
                            end
                        end
                    end
                end else if (r_adv_run) begin
                    if (adv_done) begin
                        n_tick = '0;
                        n_led  = !r_led;
                    end else begin
                        n_tick = tick_nxt[CW-1:0];
                    end
                end
            end
            slbc_pkg::ITEM_LINK: begin
                n_link = link_new;
                if (!r_active) begin
                    n_adv_run = ra_adv_run;
                    n_led     = ra_led;
                    if (ra_adv_run) begin
                        n_tick = '0;
                    end
                end
            end
            slbc_pkg::ITEM_LAYER: begin
                if (r_in.layer_activated && r_link == slbc_pkg::LINK_CONN &&
                    r_in.highest_layer != '0) begin
                    n_req = r_in.highest_layer;
                    if (r_active) begin
                        n_pending = 1'b1;
                    end else begin
                        n_active   = 1'b1;
                        n_adv_run  = 1'b0;
                        n_left     = r_in.highest_layer;
                        n_phase_on = 1'b0;
                        n_led      = 1'b0;
                        n_tick     = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adv_ticks  <= slbc_pkg::ADV_TICKS_RST;
            r_step_ticks <= slbc_pkg::STEP_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                slbc_pkg::CFG_ADV_TICKS:  r_adv_ticks  <= i_cfg_data;
                slbc_pkg::CFG_STEP_TICKS: r_step_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_link      <= slbc_pkg::LINK_OFF;
            r_led       <= 1'b0;
            r_adv_run   <= 1'b0;
            r_active    <= 1'b0;
            r_phase_on  <= 1'b0;
            r_left      <= '0;
            r_req       <= '0;
            r_pending   <= 1'b0;
            r_tick      <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_link      <= n_link;
                r_led       <= n_led;
                r_adv_run   <= n_adv_run;
                r_active    <= n_active;
                r_phase_on  <= n_phase_on;
                r_left      <= n_left;
                r_req       <= n_req;
                r_pending   <= n_pending;
                r_tick      <= n_tick;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.data;
        end
        if (fire) begin
            r_out.led_on     <= n_led;
            r_out.blink_busy <= n_active;
        end
    end

endmodule

// File: rtl/slbc_chk.sv
module slbc_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    slbc_in_if.sink     i_in,
    slbc_out_if.source  o_out
);

    // input side only backs up when the result register is held
    ap_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input ready low without a held result");

    // a beat taken into an empty pipe reaches the result register behind the input register
    ap_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !o_out.valid) |=> ##1 o_out.valid)
        else $error("result missing after accepted beat");

    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> o_out.valid)
        else $error("result valid dropped while stalled");

    ap_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> $stable(o_out.data))
        else $error("result payload changed while stalled");

endmodule

bind status_led_blink_controller slbc_chk u_slbc_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out)
);

// File: bench/tb_status_led_blink_controller.sv
module tb_status_led_blink_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import slbc_pkg::*;

    localparam int          CLK_HALF    = 10;
    localparam int          RESET_LEN   = 9;
    localparam int          TAIL_CYCLES = 4;
    localparam int          LONG_HOLD   = 80;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam logic [1:0]  ITEM_UNUSED = 2'd3;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic                i_cfg_idx;
    logic [CNT_W-1:0]    i_cfg_data;

    slbc_in_if  in_bus ();
    slbc_out_if out_bus ();

    t_out_item   led_expect_q[$];
    int          fault_count = 0;
    int unsigned cycle_count = 0;
    bit          idle_on     = 1'b1;
    logic        sink_hold   = 1'b0;

    // predictor state
    logic [CNT_W-1:0]   m_adv_period  = ADV_TICKS_RST;
    logic [CNT_W-1:0]   m_step_period = STEP_TICKS_RST;
    logic [1:0]         m_link        = LINK_OFF;
    logic               m_led         = 1'b0;
    logic               m_adv_on      = 1'b0;
    logic               m_run_active  = 1'b0;
    logic               m_run_lit     = 1'b0;
    logic               m_req_waiting = 1'b0;
    logic [LAYER_W-1:0] m_blinks_rem  = '0;
    logic [LAYER_W-1:0] m_req_count   = '0;
    logic [CNT_W-1:0]   m_ticks       = '0;

    status_led_blink_controller uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic bit period_elapsed(input logic [CNT_W-1:0] period);
        logic [CNT_W:0] nxt;
        nxt = {1'b0, m_ticks} + 1'b1;
        if (nxt >= {1'b0, period}) begin
            m_ticks = '0;
            return 1'b1;
        end
        m_ticks = nxt[CNT_W-1:0];
        return 1'b0;
    endfunction

    function automatic void run_begin(input logic [LAYER_W-1:0] count);
        m_run_active = 1'b1;
        m_adv_on     = 1'b0;
        m_blinks_rem = count;
        m_run_lit    = 1'b0;
        m_led        = 1'b0;
        m_ticks      = '0;
    endfunction

    function automatic void link_restore();
        if (m_link == LINK_ADV) begin
            m_adv_on = 1'b1;
            m_led    = ~m_led;
            m_ticks  = '0;
        end else if (m_link == LINK_CONN) begin
            m_adv_on = 1'b0;
            m_led    = 1'b1;
        end else begin
            m_adv_on = 1'b0;
            m_led    = 1'b0;
        end
    endfunction

    function automatic t_out_item predict_led(input t_in_item it);
        t_out_item res;
        case (it.mode)
            ITEM_TICK: begin
                if (m_run_active) begin
                    if (period_elapsed(m_step_period)) begin
                        if (!m_run_lit) begin
                            m_run_lit = 1'b1;
                            m_led     = 1'b1;
                        end else begin
                            if (m_blinks_rem != 0) m_blinks_rem = m_blinks_rem - 1'b1;
                            if (m_blinks_rem != 0) begin
                                m_run_lit = 1'b0;
                                m_led     = 1'b0;
                            end else begin
                                m_run_active = 1'b0;
                                m_run_lit    = 1'b0;
                                if (m_req_waiting && m_req_count != 0) begin
                                    m_req_waiting = 1'b0;
                                    run_begin(m_req_count);
                                end else begin
                                    m_req_waiting = 1'b0;
                                    link_restore();
                                end
                            end
                        end
                    end
                end else if (m_adv_on) begin
                    if (period_elapsed(m_adv_period)) m_led = ~m_led;
                end
            end
            ITEM_LINK: begin
                if (it.link_connected) m_link = LINK_CONN;
                else if (it.link_open) m_link = LINK_ADV;
                else m_link = LINK_OFF;
                if (!m_run_active) link_restore();
            end
            ITEM_LAYER: begin
                if (it.layer_activated && m_link == LINK_CONN && it.highest_layer != 0) begin
                    m_req_count = it.highest_layer;
                    if (m_run_active) m_req_waiting = 1'b1;
                    else run_begin(it.highest_layer);
                end
            end
            default: ;
        endcase
        res.led_on     = m_led;
        res.blink_busy = m_run_active;
        return res;
    endfunction

    task automatic log_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    // result sink: random stalls, long hold-off on request, field checks
    initial begin : result_check
        int        stall_left;
        bit        got_beat;
        t_out_item want;
        stall_left = 0;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            got_beat = i_rst_n && out_bus.valid && out_bus.ready;
            if (got_beat) begin
                if (led_expect_q.size() == 0) begin
                    log_fault($sformatf("beat with none expected: led_on %0b blink_busy %0b",
                                        out_bus.data.led_on, out_bus.data.blink_busy));
                end else begin
                    want = led_expect_q.pop_front();
                    if (out_bus.data.led_on !== want.led_on)
                        log_fault($sformatf("led_on expected %0b got %0b",
                                            want.led_on, out_bus.data.led_on));
                    if (out_bus.data.blink_busy !== want.blink_busy)
                        log_fault($sformatf("blink_busy expected %0b got %0b",
                                            want.blink_busy, out_bus.data.blink_busy));
                end
                stall_left = idle_on ? $urandom_range(0, 4) : 0;
            end
            if (sink_hold) begin
                out_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic link_up, input logic adv_open,
                             input logic layer_on, input logic [LAYER_W-1:0] layer_no);
        t_in_item it;
        int       gap;
        it.mode            = kind;
        it.link_connected  = link_up;
        it.link_open       = adv_open;
        it.layer_activated = layer_on;
        it.highest_layer   = layer_no;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.data  <= it;
        do @(posedge i_clk); while (!in_bus.ready);
        led_expect_q.push_back(predict_led(it));
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(ITEM_TICK, 1'($urandom), 1'($urandom), 1'($urandom),
                             LAYER_W'($urandom));
    endtask

    task automatic send_link(input logic link_up, input logic adv_open);
        send_item(ITEM_LINK, link_up, adv_open, 1'($urandom), LAYER_W'($urandom));
    endtask

    task automatic send_layer(input logic layer_on, input logic [LAYER_W-1:0] layer_no);
        send_item(ITEM_LAYER, 1'($urandom), 1'($urandom), layer_on, layer_no);
    endtask

    task automatic drain_results();
        in_bus.valid <= 1'b0;
        while (led_expect_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tick_reg(input logic idx, input logic [CNT_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_ADV_TICKS) m_adv_period = value;
        else m_step_period = value;
    endtask

    task automatic send_random_episode(inout int sent);
        int                 pick;
        int                 burst;
        logic               act;
        logic [LAYER_W-1:0] lyr;
        pick = $urandom_range(0, 99);
        lyr  = LAYER_W'($urandom);
        if (pick < 40) begin
            burst = $urandom_range(1, 8);
            send_ticks(burst);
            sent += burst;
        end else if (pick < 55) begin
            send_link($urandom_range(0, 99) < 65, 1'($urandom));
            sent++;
        end else if (pick < 95) begin
            act = $urandom_range(0, 7) != 0;
            // keep accepted runs short; wide counts only where they are ignored
            if (act && m_link == LINK_CONN)
                lyr = ($urandom_range(0, 9) == 0) ? LAYER_W'($urandom_range(0, 12))
                                                  : LAYER_W'($urandom_range(1, 3));
            send_layer(act, lyr);
            sent++;
        end else begin
            send_item(ITEM_UNUSED, 1'($urandom), 1'($urandom), 1'($urandom), lyr);
            sent++;
        end
    endtask

    task automatic test_unused_kind();
        send_item(ITEM_UNUSED, 1'b1, 1'b1, 1'b1, 8'hFF);
        send_item(ITEM_UNUSED, 1'b0, 1'b0, 1'b0, 8'h00);
    endtask

    task automatic test_advertising();
        send_link(1'b0, 1'b1);
        send_ticks(3);
        drain_results();
        write_tick_reg(CFG_ADV_TICKS, 16'd2);
        write_tick_reg(CFG_STEP_TICKS, 16'd1);
        send_ticks(5);
        send_link(1'b0, 1'b1);
        send_ticks(2);
        send_link(1'b1, 1'b1);
        send_link(1'b1, 1'b0);
        send_link(1'b0, 1'b0);
        send_ticks(2);
    endtask

    task automatic test_layer_runs();
        send_layer(1'b1, 8'd3);
        send_link(1'b1, 1'b0);
        send_layer(1'b0, 8'hA5);
        send_layer(1'b1, 8'd0);
        send_layer(1'b1, 8'd2);
        send_item(ITEM_UNUSED, 1'b0, 1'b1, 1'b0, 8'h5A);
        send_layer(1'b1, 8'd3);
        send_layer(1'b1, 8'd1);
        send_ticks(3);
        send_link(1'b0, 1'b1);
        send_ticks(5);
        send_layer(1'b1, 8'd2);
        send_link(1'b0, 1'b0);
        send_layer(1'b1, 8'd4);
    endtask

    task automatic test_period_extremes();
        drain_results();
        write_tick_reg(CFG_ADV_TICKS, 16'hFFFF);
        send_link(1'b0, 1'b1);
        send_ticks(4);
        drain_results();
        write_tick_reg(CFG_ADV_TICKS, 16'd3);
        send_ticks(4);
        drain_results();
        write_tick_reg(CFG_ADV_TICKS, 16'd0);
        send_ticks(3);
        drain_results();
        write_tick_reg(CFG_STEP_TICKS, 16'hFFFF);
        send_link(1'b1, 1'b0);
        send_layer(1'b1, 8'd1);
        send_ticks(3);
        drain_results();
        write_tick_reg(CFG_STEP_TICKS, 16'd0);
        send_ticks(3);
        send_layer(1'b1, 8'd2);
        send_ticks(4);
    endtask

    task automatic test_longest_run();
        drain_results();
        write_tick_reg(CFG_STEP_TICKS, 16'd1);
        write_tick_reg(CFG_ADV_TICKS, 16'd1);
        send_link(1'b1, 1'b0);
        send_layer(1'b1, 8'hFF);
        idle_on = 1'b0;
        send_ticks(514);
        idle_on = 1'b1;
    endtask

    task automatic test_stall_fill();
        int sent;
        sent    = 0;
        idle_on = 1'b0;
        fork
            begin
                sink_hold <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                sink_hold <= 1'b0;
            end
        join_none
        while (sent < 40) send_random_episode(sent);
        idle_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        int sent;
        repeat (3) begin
            sent = 0;
            while (sent < 12) send_random_episode(sent);
            drain_results();
        end
    endtask

    task automatic test_random_traffic();
        int               sent;
        logic [CNT_W-1:0] adv_set [4];
        logic [CNT_W-1:0] step_set[4];
        adv_set  = '{16'd2, 16'd5, 16'd0, CNT_W'($urandom_range(1, 9))};
        step_set = '{16'd1, 16'd3, 16'd2, CNT_W'($urandom_range(1, 4))};
        for (int ph = 0; ph < 4; ph++) begin
            drain_results();
            write_tick_reg(CFG_ADV_TICKS, adv_set[ph]);
            write_tick_reg(CFG_STEP_TICKS, step_set[ph]);
            sent = 0;
            while (sent < 35) begin
                if ($urandom_range(0, 29) == 0) idle_on = !idle_on;
                send_random_episode(sent);
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin : main_seq
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_ADV_TICKS;
        i_cfg_data    <= '0;
        in_bus.valid  <= 1'b0;
        in_bus.data   <= '0;
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unused_kind();
        test_advertising();
        test_layer_runs();
        test_period_extremes();
        test_longest_run();
        test_stall_fill();
        test_sender_pause();
        test_random_traffic();
        drain_results();

        if (fault_count == 0 && led_expect_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
